@@ hdl/stt_pkg.sv @@
// Shared constants, opcodes and types for the software timer table.
package stt_pkg;

   localparam int MAX_RESULTS = 16;
   localparam int LIST_W      = $clog2(MAX_RESULTS);
   localparam int NUM_W       = $clog2(MAX_RESULTS + 1);

   localparam logic [31:0] WINDOW_RESET = 32'd3600000;
   localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam logic [2:0] OP_ADD     = 3'd0;
   localparam logic [2:0] OP_CANCEL  = 3'd1;
   localparam logic [2:0] OP_REFRESH = 3'd2;
   localparam logic [2:0] OP_RESET   = 3'd3;
   localparam logic [2:0] OP_EXPIRE  = 3'd4;
   localparam logic [2:0] OP_QUERY   = 3'd5;

   typedef struct packed {
      logic deadline;
      logic period;
   } mem_we_type;

endpackage

@@ hdl/stt_if.sv @@
// Request and response channel interfaces of the software timer table.
interface stt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [63:0] now_ms;
   logic [3:0]  slot_id;
   logic [63:0] period_ms;
   logic        repeat_mode;
   logic        restart_now;

   modport source (output valid, opcode, now_ms, slot_id, period_ms, repeat_mode, restart_now,
                   input ready);
   modport sink (input valid, opcode, now_ms, slot_id, period_ms, repeat_mode, restart_now,
                 output ready);
endinterface

interface stt_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [3:0]  timer_id;
   logic        expired_valid;
   logic [63:0] wait_ms;
   logic        front_notify;
   logic        any_active;
   logic        last;

   modport source (output valid, ok, timer_id, expired_valid, wait_ms, front_notify,
                   any_active, last, input ready);
   modport sink (input valid, ok, timer_id, expired_valid, wait_ms, front_notify,
                 any_active, last, output ready);
endinterface

@@ hdl/software_timer_table.sv @@
// Timer table of NUM_TIMERS slots driven by a sequencer around one compare scan: one item at a
// time. Cancel, refresh and an unchanged reset need no scan; a reset that changes the timer
// adds a front scan, add a free-slot search and, if a slot is free, a front scan, query one
// scan, and expire one scan per expired timer (plus the read and write states S_EXPRD and
// S_EXPWR for a recurring rearm, at most 16 timers), one closing scan that finds none unless
// 16 were found, and then one response per reported timer. Every result also waits for the
// receiver. The cost is set by the single read port of the deadline store, which the scan
// walks one slot per cycle.
module software_timer_table #(
   parameter int NUM_TIMERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   stt_req_if.sink     req_ch,
   stt_rsp_if.source   rsp_ch,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   localparam int IW = $clog2(NUM_TIMERS);
   localparam int CW = $clog2(NUM_TIMERS + 1);
   localparam logic [CW-1:0] CNT_END = CW'(NUM_TIMERS);
   localparam logic [stt_pkg::NUM_W-1:0] NUM_MAX = stt_pkg::NUM_W'(stt_pkg::MAX_RESULTS);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DISP   = 4'd1;
   localparam logic [3:0] S_FIND   = 4'd2;
   localparam logic [3:0] S_SLOTRD = 4'd3;
   localparam logic [3:0] S_RSTWR  = 4'd4;
   localparam logic [3:0] S_SCAN   = 4'd5;
   localparam logic [3:0] S_EXPRD  = 4'd6;
   localparam logic [3:0] S_EXPWR  = 4'd7;
   localparam logic [3:0] S_OUT    = 4'd8;
   localparam logic [3:0] S_EMIT   = 4'd9;

   localparam logic [1:0] K_FRONT  = 2'd0;
   localparam logic [1:0] K_QUERY  = 2'd1;
   localparam logic [1:0] K_EXPIRE = 2'd2;

   logic [3:0]            state_ff, state_in;
   logic [1:0]            kind_ff, kind_in;
   logic [NUM_TIMERS-1:0] active_ff, active_in;
   logic [NUM_TIMERS-1:0] repeat_ff, repeat_in;
   logic [NUM_TIMERS-1:0] taken_ff, taken_in;
   logic                  pending_ff, pending_in;
   logic [63:0]           prev_ff, prev_in;
   logic [31:0]           window_ff, window_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  chk_vld_ff, chk_vld_in;

   logic [2:0]            op_ff, op_in;
   logic [63:0]           now_ff, now_in;
   logic [3:0]            sid_ff, sid_in;
   logic [63:0]           per_ff, per_in;
   logic                  rep_ff, rep_in;
   logic                  fnow_ff, fnow_in;
   logic                  roll_ff, roll_in;
   logic [IW-1:0]         chk_idx_ff, chk_idx_in;
   logic                  found_ff, found_in;
   logic [IW-1:0]         best_ff, best_in;
   logic [63:0]           best_dl_ff, best_dl_in;
   logic [IW-1:0]         tgt_ff, tgt_in;
   logic [63:0]           tmp_ff, tmp_in;
   logic [stt_pkg::NUM_W-1:0] n_ff, n_in;
   logic [stt_pkg::NUM_W-1:0] ecnt_ff, ecnt_in;
   logic [IW-1:0]         list_ff [stt_pkg::MAX_RESULTS];
   logic [IW-1:0]         list_in [stt_pkg::MAX_RESULTS];
   logic                  res_ok_ff, res_ok_in;
   logic [3:0]            res_id_ff, res_id_in;
   logic [63:0]           res_wait_ff, res_wait_in;
   logic                  res_fn_ff, res_fn_in;

   logic                  rsp_ok_ff, rsp_ok_in;
   logic [3:0]            rsp_id_ff, rsp_id_in;
   logic                  rsp_ev_ff, rsp_ev_in;
   logic [63:0]           rsp_wait_ff, rsp_wait_in;
   logic                  rsp_fn_ff, rsp_fn_in;
   logic                  rsp_any_ff, rsp_any_in;
   logic                  rsp_last_ff, rsp_last_in;

   stt_pkg::mem_we_type   mem_we;
   logic [IW-1:0]         wr_addr, rd_addr;
   logic [63:0]           wr_dl, wr_per, rd_dl, rd_per;

   logic                  rsp_free;
   logic                  sid_valid;
   logic [IW-1:0]         sid_idx;
   logic [IW-1:0]         cnt_idx;
   logic [63:0]           oldp;
   logic                  elig;
   logic [stt_pkg::NUM_W-1:0] n_next;

   stt_slot_mem #(
      .DEPTH (NUM_TIMERS)
   ) u_mem (
      .clock       (clock),
      .wr_en       (mem_we),
      .wr_addr     (wr_addr),
      .wr_deadline (wr_dl),
      .wr_period   (wr_per),
      .rd_addr     (rd_addr),
      .rd_deadline (rd_dl),
      .rd_period   (rd_per)
   );

   assign req_ch.ready         = (state_ff == S_IDLE);
   assign rsp_ch.valid         = rsp_vld_ff;
   assign rsp_ch.ok            = rsp_ok_ff;
   assign rsp_ch.timer_id      = rsp_id_ff;
   assign rsp_ch.expired_valid = rsp_ev_ff;
   assign rsp_ch.wait_ms       = rsp_wait_ff;
   assign rsp_ch.front_notify  = rsp_fn_ff;
   assign rsp_ch.any_active    = rsp_any_ff;
   assign rsp_ch.last          = rsp_last_ff;

   assign rsp_free  = !rsp_vld_ff || rsp_ch.ready;
   assign sid_valid = (32'(sid_ff) < 32'(NUM_TIMERS));
   assign sid_idx   = IW'(sid_ff);
   assign cnt_idx   = cnt_ff[IW-1:0];
   assign oldp      = sid_valid ? rd_per : 64'd0;
   assign n_next    = n_ff + 1'b1;
   assign elig      = active_ff[chk_idx_ff] &&
                      ((kind_ff != K_EXPIRE) ||
                       (!taken_ff[chk_idx_ff] && (roll_ff || rd_dl <= now_ff)));

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      active_in   = active_ff;
      repeat_in   = repeat_ff;
      taken_in    = taken_ff;
      pending_in  = pending_ff;
      prev_in     = prev_ff;
      window_in   = window_ff;
      rsp_vld_in  = rsp_vld_ff;
      cnt_in      = cnt_ff;
      chk_vld_in  = 1'b0;
      op_in       = op_ff;
      now_in      = now_ff;
      sid_in      = sid_ff;
      per_in      = per_ff;
      rep_in      = rep_ff;
      fnow_in     = fnow_ff;
      roll_in     = roll_ff;
      chk_idx_in  = chk_idx_ff;
      found_in    = found_ff;
      best_in     = best_ff;
      best_dl_in  = best_dl_ff;
      tgt_in      = tgt_ff;
      tmp_in      = tmp_ff;
      n_in        = n_ff;
      ecnt_in     = ecnt_ff;
      list_in     = list_ff;
      res_ok_in   = res_ok_ff;
      res_id_in   = res_id_ff;
      res_wait_in = res_wait_ff;
      res_fn_in   = res_fn_ff;
      rsp_ok_in   = rsp_ok_ff;
      rsp_id_in   = rsp_id_ff;
      rsp_ev_in   = rsp_ev_ff;
      rsp_wait_in = rsp_wait_ff;
      rsp_fn_in   = rsp_fn_ff;
      rsp_any_in  = rsp_any_ff;
      rsp_last_in = rsp_last_ff;
      mem_we      = '0;
      wr_addr     = sid_idx;
      wr_dl       = now_ff + per_ff;
      wr_per      = per_ff;
      rd_addr     = sid_idx;

      if (rsp_vld_ff && rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end
      if (csr_write_enable) begin
         window_in = csr_write_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in    = req_ch.opcode;
               now_in   = req_ch.now_ms;
               sid_in   = req_ch.slot_id;
               per_in   = req_ch.period_ms;
               rep_in   = req_ch.repeat_mode;
               fnow_in  = req_ch.restart_now;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            res_ok_in   = 1'b0;
            res_id_in   = 4'd0;
            res_wait_in = 64'd0;
            res_fn_in   = 1'b0;
            cnt_in      = '0;
            found_in    = 1'b0;
            unique case (op_ff) inside
               stt_pkg::OP_ADD: begin
                  state_in = S_FIND;
               end
               stt_pkg::OP_CANCEL: begin
                  if (sid_valid && active_ff[sid_idx]) begin
                     active_in[sid_idx] = 1'b0;
                     res_ok_in          = 1'b1;
                  end
                  state_in = S_OUT;
               end
               stt_pkg::OP_REFRESH, stt_pkg::OP_RESET: begin
                  state_in = S_SLOTRD;
               end
               stt_pkg::OP_EXPIRE: begin
                  res_ok_in = 1'b1;
                  if (|active_ff) begin
                     roll_in  = (now_ff < prev_ff) &&
                                ((prev_ff - now_ff) > {32'd0, window_ff});
                     prev_in  = now_ff;
                     taken_in = '0;
                     n_in     = '0;
                     kind_in  = K_EXPIRE;
                     state_in = S_SCAN;
                  end else begin
                     state_in = S_OUT;
                  end
               end
               stt_pkg::OP_QUERY: begin
                  kind_in  = K_QUERY;
                  state_in = S_SCAN;
               end
               default: begin
                  state_in = S_OUT;
               end
            endcase
         end
         S_FIND: begin
            if (cnt_ff == CNT_END) begin
               state_in = S_OUT;
            end else if (!active_ff[cnt_idx]) begin
               mem_we             = '{deadline: 1'b1, period: 1'b1};
               wr_addr            = cnt_idx;
               active_in[cnt_idx] = 1'b1;
               repeat_in[cnt_idx] = rep_ff;
               tgt_in             = cnt_idx;
               res_ok_in          = 1'b1;
               res_id_in          = 4'(cnt_idx);
               cnt_in             = '0;
               kind_in            = K_FRONT;
               state_in           = S_SCAN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_SLOTRD: begin
            state_in = S_OUT;
            if (op_ff == stt_pkg::OP_REFRESH) begin
               if (sid_valid && active_ff[sid_idx]) begin
                  mem_we.deadline = 1'b1;
                  wr_dl           = now_ff + rd_per;
                  res_ok_in       = 1'b1;
               end
            end else if (per_ff == oldp && !fnow_ff) begin
               res_ok_in = 1'b1;
            end else if (sid_valid && active_ff[sid_idx]) begin
               tmp_in   = fnow_ff ? now_ff : rd_dl - oldp;
               state_in = S_RSTWR;
            end
         end
         S_RSTWR: begin
            mem_we    = '{deadline: 1'b1, period: 1'b1};
            wr_dl     = tmp_ff + per_ff;
            res_ok_in = 1'b1;
            tgt_in    = sid_idx;
            kind_in   = K_FRONT;
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            if (cnt_ff != CNT_END) begin
               rd_addr    = cnt_idx;
               cnt_in     = cnt_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = cnt_idx;
            end
            if (chk_vld_ff && elig && (!found_ff || rd_dl < best_dl_ff)) begin
               found_in   = 1'b1;
               best_in    = chk_idx_ff;
               best_dl_in = rd_dl;
            end
            if (cnt_ff == CNT_END && !chk_vld_ff) begin
               unique case (kind_ff)
                  K_FRONT: begin
                     if (found_ff && best_ff == tgt_ff && !pending_ff) begin
                        res_fn_in  = 1'b1;
                        pending_in = 1'b1;
                     end
                     state_in = S_OUT;
                  end
                  K_QUERY: begin
                     pending_in = 1'b0;
                     res_ok_in  = 1'b1;
                     if (!found_ff) begin
                        res_wait_in = stt_pkg::ALL_ONES;
                     end else if (now_ff >= best_dl_ff) begin
                        res_wait_in = 64'd0;
                     end else begin
                        res_wait_in = best_dl_ff - now_ff;
                     end
                     state_in = S_OUT;
                  end
                  K_EXPIRE: begin
                     ecnt_in = '0;
                     if (!found_ff) begin
                        state_in = (n_ff == '0) ? S_OUT : S_EMIT;
                     end else begin
                        list_in[n_ff[stt_pkg::LIST_W-1:0]] = best_ff;
                        taken_in[best_ff] = 1'b1;
                        n_in              = n_next;
                        if (repeat_ff[best_ff]) begin
                           state_in = S_EXPRD;
                        end else begin
                           active_in[best_ff] = 1'b0;
                           if (n_next == NUM_MAX) begin
                              state_in = S_EMIT;
                           end else begin
                              cnt_in   = '0;
                              found_in = 1'b0;
                           end
                        end
                     end
                  end
                  default: begin
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_EXPRD: begin
            rd_addr  = best_ff;
            state_in = S_EXPWR;
         end
         S_EXPWR: begin
            rd_addr         = best_ff;
            mem_we.deadline = 1'b1;
            wr_addr         = best_ff;
            wr_dl           = now_ff + rd_per;
            cnt_in          = '0;
            found_in        = 1'b0;
            ecnt_in         = '0;
            state_in        = (n_ff == NUM_MAX) ? S_EMIT : S_SCAN;
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_vld_in  = 1'b1;
               rsp_ok_in   = res_ok_ff;
               rsp_id_in   = res_id_ff;
               rsp_ev_in   = 1'b0;
               rsp_wait_in = res_wait_ff;
               rsp_fn_in   = res_fn_ff;
               rsp_any_in  = |active_ff;
               rsp_last_in = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_vld_in  = 1'b1;
               rsp_ok_in   = 1'b1;
               rsp_id_in   = 4'(list_ff[ecnt_ff[stt_pkg::LIST_W-1:0]]);
               rsp_ev_in   = 1'b1;
               rsp_wait_in = 64'd0;
               rsp_fn_in   = 1'b0;
               rsp_any_in  = |active_ff;
               rsp_last_in = (ecnt_ff + 1'b1 == n_ff);
               ecnt_in     = ecnt_ff + 1'b1;
               if (ecnt_ff + 1'b1 == n_ff) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         kind_ff    <= K_FRONT;
         active_ff  <= '0;
         repeat_ff  <= '0;
         taken_ff   <= '0;
         pending_ff <= 1'b0;
         prev_ff    <= 64'd0;
         window_ff  <= stt_pkg::WINDOW_RESET;
         rsp_vld_ff <= 1'b0;
         cnt_ff     <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         kind_ff    <= kind_in;
         active_ff  <= active_in;
         repeat_ff  <= repeat_in;
         taken_ff   <= taken_in;
         pending_ff <= pending_in;
         prev_ff    <= prev_in;
         window_ff  <= window_in;
         rsp_vld_ff <= rsp_vld_in;
         cnt_ff     <= cnt_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      now_ff      <= now_in;
      sid_ff      <= sid_in;
      per_ff      <= per_in;
      rep_ff      <= rep_in;
      fnow_ff     <= fnow_in;
      roll_ff     <= roll_in;
      chk_idx_ff  <= chk_idx_in;
      found_ff    <= found_in;
      best_ff     <= best_in;
      best_dl_ff  <= best_dl_in;
      tgt_ff      <= tgt_in;
      tmp_ff      <= tmp_in;
      n_ff        <= n_in;
      ecnt_ff     <= ecnt_in;
      list_ff     <= list_in;
      res_ok_ff   <= res_ok_in;
      res_id_ff   <= res_id_in;
      res_wait_ff <= res_wait_in;
      res_fn_ff   <= res_fn_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_ev_ff   <= rsp_ev_in;
      rsp_wait_ff <= rsp_wait_in;
      rsp_fn_ff   <= rsp_fn_in;
      rsp_any_ff  <= rsp_any_in;
      rsp_last_ff <= rsp_last_in;
   end

`ifndef SYNTHESIS
   a_list_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (n_ff <= NUM_MAX && n_ff != '0))
      else $error("expire list count out of range");

   a_notify_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_free && res_fn_ff) |=> pending_ff)
      else $error("front notice sent without pending mark");

   a_scan_index: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> (32'(chk_idx_ff) < 32'(NUM_TIMERS)))
      else $error("scan index beyond table");
`endif

endmodule

@@ hdl/stt_slot_mem.sv @@
// Deadline and period store: one write port, one registered read port.
module stt_slot_mem #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  stt_pkg::mem_we_type      wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [63:0]              wr_deadline,
   input  logic [63:0]              wr_period,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [63:0]              rd_deadline,
   output logic [63:0]              rd_period
);

   logic [63:0] deadline_mem [DEPTH];
   logic [63:0] period_mem   [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en.deadline) begin
         deadline_mem[wr_addr] <= wr_deadline;
      end
      if (wr_en.period) begin
         period_mem[wr_addr] <= wr_period;
      end
      rd_deadline <= deadline_mem[rd_addr];
      rd_period   <= period_mem[rd_addr];
   end

endmodule

@@ bench/stt_checker.sv @@
// Checker for the software timer table: predicts results from accepted requests and compares.
module stt_checker (
   input  logic        clock,
   input  logic        reset,
   stt_req_if          req_ch,
   stt_rsp_if          rsp_ch,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   output int          fail_count,
   output int          pending_count,
   output int          result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NT = 16;

   typedef struct packed {
      logic        ok;
      logic [3:0]  timer_id;
      logic        expired_valid;
      logic [63:0] wait_ms;
      logic        front_notify;
      logic        any_active;
      logic        last;
   } timer_result_type;

   logic        t_active [NT];
   logic        t_repeat [NT];
   logic [63:0] t_period [NT];
   logic [63:0] t_deadline [NT];
   logic [63:0] last_now;
   logic        notice;
   logic [31:0] window;

   timer_result_type expected_results[$];

   function automatic bit earlier(int a, int b);
      if (t_deadline[a] != t_deadline[b]) return t_deadline[a] < t_deadline[b];
      return a < b;
   endfunction

   function automatic bit table_busy();
      foreach (t_active[i]) if (t_active[i]) return 1'b1;
      return 1'b0;
   endfunction

   function automatic int earliest_slot();
      int best;
      best = -1;
      for (int i = 0; i < NT; i++)
         if (t_active[i] && (best < 0 || earlier(i, best))) best = i;
      return best;
   endfunction

   function automatic bit front_check(int s);
      bit fire;
      fire = (earliest_slot() == s) && !notice;
      if (fire) notice = 1'b1;
      return fire;
   endfunction

   task automatic predict_timer_op(logic [2:0] op, logic [63:0] now, logic [3:0] sid,
                                   logic [63:0] per, logic rep, logic fnow);
      timer_result_type r;
      bit taken [NT];
      int fired[$];
      int best, f;
      bit roll, any;
      logic [63:0] start;
      r = '0;
      case (op)
         stt_pkg::OP_ADD: begin
            for (int i = 0; i < NT; i++) begin
               if (!t_active[i]) begin
                  t_active[i] = 1'b1;
                  t_repeat[i] = rep;
                  t_period[i] = per;
                  t_deadline[i] = now + per;
                  r.ok = 1'b1;
                  r.timer_id = 4'(i);
                  r.front_notify = front_check(i);
                  break;
               end
            end
         end
         stt_pkg::OP_CANCEL: begin
            if (t_active[sid]) begin
               t_active[sid] = 1'b0;
               r.ok = 1'b1;
            end
         end
         stt_pkg::OP_REFRESH: begin
            if (t_active[sid]) begin
               t_deadline[sid] = now + t_period[sid];
               r.ok = 1'b1;
            end
         end
         stt_pkg::OP_RESET: begin
            if (per == t_period[sid] && !fnow) begin
               r.ok = 1'b1;
            end else if (t_active[sid]) begin
               start = fnow ? now : t_deadline[sid] - t_period[sid];
               t_period[sid] = per;
               t_deadline[sid] = start + per;
               r.ok = 1'b1;
               r.front_notify = front_check(sid);
            end
         end
         stt_pkg::OP_EXPIRE: begin
            r.ok = 1'b1;
            if (table_busy()) begin
               roll = now < last_now && (last_now - now) > {32'd0, window};
               last_now = now;
               foreach (taken[i]) taken[i] = 1'b0;
               while (fired.size() < stt_pkg::MAX_RESULTS) begin
                  best = -1;
                  for (int i = 0; i < NT; i++)
                     if (t_active[i] && !taken[i] && (roll || t_deadline[i] <= now) &&
                         (best < 0 || earlier(i, best))) best = i;
                  if (best < 0) break;
                  taken[best] = 1'b1;
                  fired = {fired, best};
               end
               foreach (fired[k]) begin
                  if (t_repeat[fired[k]]) t_deadline[fired[k]] = now + t_period[fired[k]];
                  else t_active[fired[k]] = 1'b0;
               end
               any = table_busy();
               foreach (fired[k]) begin
                  r = '0;
                  r.ok = 1'b1;
                  r.timer_id = 4'(fired[k]);
                  r.expired_valid = 1'b1;
                  r.any_active = any;
                  r.last = (k == fired.size() - 1);
                  expected_results = {expected_results, r};
               end
               if (fired.size() > 0) return;
            end
         end
         stt_pkg::OP_QUERY: begin
            f = earliest_slot();
            notice = 1'b0;
            r.ok = 1'b1;
            if (f < 0) r.wait_ms = stt_pkg::ALL_ONES;
            else if (now >= t_deadline[f]) r.wait_ms = '0;
            else r.wait_ms = t_deadline[f] - now;
         end
         default: ;
      endcase
      r.any_active = table_busy();
      r.last = 1'b1;
      expected_results = {expected_results, r};
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   timer_result_type got, want;

   always @(posedge clock) begin
      if (reset) begin
         foreach (t_active[i]) begin
            t_active[i] = 1'b0;
            t_repeat[i] = 1'b0;
            t_period[i] = '0;
            t_deadline[i] = '0;
         end
         last_now = '0;
         notice = 1'b0;
         window = stt_pkg::WINDOW_RESET;
         expected_results.delete();
         fail_count = 0;
         result_count = 0;
      end else begin
         if (csr_write_enable) window = csr_write_data;
         if (rsp_ch.valid && rsp_ch.ready) begin
            result_count++;
            got = '{rsp_ch.ok, rsp_ch.timer_id, rsp_ch.expired_valid, rsp_ch.wait_ms,
                    rsp_ch.front_notify, rsp_ch.any_active, rsp_ch.last};
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected transfer", 64'(got.timer_id), 64'd0);
            end else begin
               want = expected_results.pop_front();
               if (got.ok !== want.ok) report_mismatch("ok", 64'(got.ok), 64'(want.ok));
               if (got.timer_id !== want.timer_id)
                  report_mismatch("timer_id", 64'(got.timer_id), 64'(want.timer_id));
               if (got.expired_valid !== want.expired_valid)
                  report_mismatch("expired_valid", 64'(got.expired_valid),
                                  64'(want.expired_valid));
               if (got.wait_ms !== want.wait_ms)
                  report_mismatch("wait_ms", got.wait_ms, want.wait_ms);
               if (got.front_notify !== want.front_notify)
                  report_mismatch("front_notify", 64'(got.front_notify),
                                  64'(want.front_notify));
               if (got.any_active !== want.any_active)
                  report_mismatch("any_active", 64'(got.any_active), 64'(want.any_active));
               if (got.last !== want.last)
                  report_mismatch("last", 64'(got.last), 64'(want.last));
            end
         end
         if (req_ch.valid && req_ch.ready)
            predict_timer_op(req_ch.opcode, req_ch.now_ms, req_ch.slot_id, req_ch.period_ms,
                             req_ch.repeat_mode, req_ch.restart_now);
      end
      pending_count = expected_results.size();
   end

endmodule

@@ bench/tb.sv @@
// Top of the software timer table testbench: clock, reset, stimulus and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] OP_BAD_LO = 3'd6;
   localparam logic [2:0] OP_BAD_HI = 3'd7;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [31:0] csr_write_data;
   int          fail_count, pending_count, result_count;
   int          hold_cycles;
   bit          quiet_phase;
   int          sent;
   logic [63:0] clk_ms;

   stt_req_if req_ch ();
   stt_rsp_if rsp_ch ();

   software_timer_table uut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   stt_checker chk (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
   );

   always begin
      clock = 1;
      #5;
      clock = 0;
      #5;
   end

   initial begin
      #50ms;
      $display("timeout");
      $display("FAILURE");
      $finish;
   end

   // response side: random stall, forced hold-off window
   initial begin
      rsp_ch.ready = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ch.ready <= 0;
         end else begin
            rsp_ch.ready <= quiet_phase || ($urandom_range(99) >= 13);
         end
      end
   end

   task automatic send(logic [2:0] op, logic [63:0] now, logic [3:0] sid, logic [63:0] per,
                       logic rep, logic fnow);
      while (!quiet_phase && $urandom_range(99) < 13) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.opcode <= op;
      req_ch.now_ms <= now;
      req_ch.slot_id <= sid;
      req_ch.period_ms <= per;
      req_ch.repeat_mode <= rep;
      req_ch.restart_now <= fnow;
      do @(posedge clock); while (!req_ch.ready);
      sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_window(logic [31:0] v);
      drain();
      csr_write_enable <= 1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] small_period();
      case ($urandom_range(3))
         0: return 64'($urandom_range(0, 20));
         1: return 64'($urandom_range(0, 2000));
         2: return rand64();
         default: return 64'($urandom_range(0, 200));
      endcase
   endfunction

   initial begin
      logic [2:0]  op;
      logic [63:0] now;
      int          pick;
      reset = 1;
      csr_write_enable = 0;
      csr_write_data = '0;
      req_ch.valid = 0;
      req_ch.opcode = stt_pkg::OP_QUERY;
      req_ch.now_ms = '0;
      req_ch.slot_id = '0;
      req_ch.period_ms = '0;
      req_ch.repeat_mode = 0;
      req_ch.restart_now = 0;
      hold_cycles = 0;
      quiet_phase = 0;
      sent = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: empty table, extremes, full table, rollover
      send(stt_pkg::OP_QUERY, 64'd0, 4'd0, 64'd0, 1'b0, 1'b0);
      send(stt_pkg::OP_EXPIRE, 64'd5, 4'd0, 64'd0, 1'b0, 1'b0);
      send(stt_pkg::OP_CANCEL, 64'd0, 4'd15, 64'd0, 1'b0, 1'b0);
      send(stt_pkg::OP_ADD, 64'd100, 4'd0, 64'd50, 1'b1, 1'b0);
      send(stt_pkg::OP_ADD, '1, 4'd0, '1, 1'b0, 1'b1);
      send(stt_pkg::OP_RESET, 64'd120, 4'd0, 64'd50, 1'b0, 1'b0);
      send(stt_pkg::OP_RESET, 64'd120, 4'd0, 64'd10, 1'b0, 1'b0);
      send(stt_pkg::OP_RESET, 64'd130, 4'd1, 64'd7, 1'b0, 1'b1);
      send(stt_pkg::OP_REFRESH, 64'd140, 4'd0, 64'd0, 1'b0, 1'b0);
      send(stt_pkg::OP_REFRESH, 64'd140, 4'd9, 64'd0, 1'b0, 1'b0);
      send(stt_pkg::OP_QUERY, 64'd141, 4'd0, 64'd0, 1'b0, 1'b0);
      send(stt_pkg::OP_QUERY, 64'd900, 4'd0, 64'd0, 1'b0, 1'b0);
      for (int i = 0; i < 15; i++)
         send(stt_pkg::OP_ADD, 64'd1000, 4'd0, 64'd1, 1'(i % 2), 1'b0);
      send(stt_pkg::OP_EXPIRE, 64'd5000, 4'd0, 64'd0, 1'b0, 1'b0);
      send(stt_pkg::OP_EXPIRE, 64'd6000, 4'd0, 64'd0, 1'b0, 1'b0);
      send(stt_pkg::OP_EXPIRE, 64'd10, 4'd0, 64'd0, 1'b0, 1'b0);
      send(OP_BAD_LO, 64'd0, 4'd0, 64'd0, 1'b0, 1'b0);
      send(OP_BAD_HI, '1, 4'd15, '1, 1'b1, 1'b1);
      send(stt_pkg::OP_QUERY, '1, 4'd0, 64'd0, 1'b0, 1'b0);

      // random phases over window settings, one backpressure hold-off
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_window(32'd0);
            1: write_window('1);
            2: write_window(32'($urandom_range(0, 5000)));
            default: write_window(stt_pkg::WINDOW_RESET);
         endcase
         clk_ms = 64'($urandom_range(0, 100000));
         quiet_phase = (phase == 2);
         for (int n = 0; n < 66; n++) begin
            if (phase == 1 && n == 10) hold_cycles = 3000;
            pick = $urandom_range(99);
            if (pick < 3) clk_ms = rand64();
            else if (pick < 8) clk_ms = clk_ms - 64'($urandom_range(0, 8000));
            else clk_ms = clk_ms + 64'($urandom_range(0, 400));
            now = clk_ms;
            pick = $urandom_range(99);
            if (pick < 24) op = stt_pkg::OP_ADD;
            else if (pick < 34) op = stt_pkg::OP_CANCEL;
            else if (pick < 44) op = stt_pkg::OP_REFRESH;
            else if (pick < 58) op = stt_pkg::OP_RESET;
            else if (pick < 82) op = stt_pkg::OP_EXPIRE;
            else if (pick < 97) op = stt_pkg::OP_QUERY;
            else op = 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
            // reset with restart_now clear only on slots whose period was written
            if (op == stt_pkg::OP_RESET)
               send(op, now, 4'($urandom_range(0, 15)), small_period(),
                    1'($urandom_range(1)), 1'b1);
            else
               send(op, now, 4'($urandom_range(0, 15)), small_period(),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
            if (op == stt_pkg::OP_ADD && $urandom_range(3) == 0)
               send(stt_pkg::OP_RESET, now, 4'($urandom_range(0, 1)), small_period(),
                    1'b0, 1'b0);
         end
      end
      drain();

      $display("covered %0d requests and %0d results over four window settings,", sent,
               result_count);
      $display("including full-table, rollover and backpressure stretches");
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
